>>> hdl/sapg_pkg.sv
// Shared types, widths, constants and helper functions of the pan/gain pipeline.
package sapg_pkg;

   // Field widths
   localparam int POS_W   = 32;          // Q16.16 position
   localparam int DIR_W   = 16;          // Q1.14 facing
   localparam int VOL_W   = 16;          // Q1.15 volume / gain
   localparam int MAG_W   = POS_W + 1;   // magnitude of a position difference
   localparam int NORM_W  = 15;          // normalized component magnitude
   localparam int NORM_MSB = NORM_W - 1;
   localparam int MSB_W   = 6;           // bit index into a MAG_W vector
   localparam int SQ_W    = 32;          // sum of three squared NORM_W values
   localparam int DOT_W   = 32;          // |dot product| of two normalized vectors
   localparam int ROOT_W  = 23;          // floor sqrt of a RAD_W radicand
   localparam int RAD_W   = 2 * ROOT_W;  // squared length scaled by 2^14
   localparam int REM_W   = ROOT_W + 3;  // square root partial remainder
   localparam int DEN_W   = 2 * ROOT_W;  // product of two lengths
   localparam int NUM_W   = 62;          // rounded dividend
   localparam int QUO_W   = 17;          // quotient bits before clamping
   localparam int COS_W   = 17;          // signed Q1.15 cosine, -1 .. +1
   localparam int CSR_IDX_W = 2;

   // Constants of the arithmetic: 1.0 and 0.5 in the formats used
   localparam logic [QUO_W-1:0] COS_ONE    = 17'd32768;  // 1.0 in Q1.15
   localparam logic [17:0]      PAN_OFFSET = 18'd32769;  // 1.0 plus rounding half LSB
   localparam logic [17:0]      W_OFFSET   = 18'd32768;  // 1.0 in Q1.15
   localparam logic [17:0]      W_FULL     = 18'd65536;  // 2.0 in Q1.15
   localparam logic [33:0]      VOL_HALF   = 34'd32768;  // 0.5 LSB of a Q.31 sum
   localparam logic [32:0]      GAIN_HALF  = 33'd16384;  // 0.5 LSB of a Q.30 product
   localparam logic [VOL_W-1:0] VOL_RESET  = 16'd32768;  // 1.0
   localparam logic [VOL_W-1:0] GAIN_MAX   = 16'hFFFF;
   localparam int NORM_SHIFT_BITS = 14;  // Q1.14 scale folded into the radicand

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VOLUME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VOLUME = 2'd1;

   // Pipeline latencies
   localparam int FRONT_LAT = 3;
   localparam int ISQRT_LAT = ROOT_W;
   localparam int DEN_LAT   = 1;
   localparam int DIV_LAT   = QUO_W + 2;
   localparam int MIX_LAT   = 5;
   localparam int DOT_DLY   = ISQRT_LAT + DEN_LAT;
   localparam int ZERO_DLY  = ISQRT_LAT + DEN_LAT + DIV_LAT;
   localparam int PIPE_LAT  = FRONT_LAT + ISQRT_LAT + DEN_LAT + DIV_LAT + MIX_LAT;
   localparam int DOT_PAIR_W = 2 * (DOT_W + 1);

   typedef struct packed {
      logic signed [POS_W-1:0] listener_x;
      logic signed [POS_W-1:0] listener_y;
      logic signed [POS_W-1:0] listener_z;
      logic signed [POS_W-1:0] source_x;
      logic signed [POS_W-1:0] source_y;
      logic signed [POS_W-1:0] source_z;
      logic signed [DIR_W-1:0] listener_dir_x;
      logic signed [DIR_W-1:0] listener_dir_y;
      logic signed [DIR_W-1:0] listener_dir_z;
      logic signed [DIR_W-1:0] source_dir_x;
      logic signed [DIR_W-1:0] source_dir_y;
      logic signed [DIR_W-1:0] source_dir_z;
   } sapg_req_type;

   typedef struct packed {
      logic [VOL_W-1:0] gain;
      logic [VOL_W-1:0] pan;
      logic [VOL_W-1:0] blended_volume;
      logic             zero_length;
   } sapg_rsp_type;

   // Squared lengths and dot products leaving the front end
   typedef struct packed {
      logic [SQ_W-1:0]  aa_l;
      logic [SQ_W-1:0]  aa_d;
      logic [SQ_W-1:0]  aa_s;
      logic [DOT_W-1:0] dot1_mag;
      logic             dot1_neg;
      logic [DOT_W-1:0] dot2_mag;
      logic             dot2_neg;
      logic             zero;
   } sapg_prod_type;

   // Index of the highest set bit, 0 when none
   function automatic logic [MSB_W-1:0] msb_index(input logic [MAG_W-1:0] v);
      logic [MSB_W-1:0] p;
      p = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) p = MSB_W'(i);
      end
      return p;
   endfunction

   // Shift a magnitude so that bit p lands at NORM_MSB
   function automatic logic [NORM_W-1:0] norm_mag(input logic [MAG_W-1:0] mag,
                                                  input logic [MSB_W-1:0] p);
      logic [MAG_W-1:0] t;
      if (p >= MSB_W'(NORM_MSB)) t = mag >> (p - MSB_W'(NORM_MSB));
      else t = mag << (MSB_W'(NORM_MSB) - p);
      return t[NORM_W-1:0];
   endfunction

endpackage

>>> hdl/spatial_audio_pan_gain_unit.sv
// Top level of the spatial audio pan/gain pipeline.
//
//   Port group   Direction   Handshake              Payload
//   req_         in          req_valid / req_stall  sapg_req_type (positions, facings)
//   rsp_         out         rsp_valid / rsp_stall  sapg_rsp_type (gain, pan, volume, flag)
//   csr_         in          csr_we                 csr_index, csr_wdata
//
// One transaction enters per cycle unless stalled. Each result passes through the
// front end, the 23-stage square root, the length products, the 17-step divider
// and the mix stages. Reset clears the valid pipeline and sets both volumes to 1.0.
// A held-up result freezes the whole pipeline and stalls the request side.
module spatial_audio_pan_gain_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sapg_pkg::sapg_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sapg_pkg::sapg_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [sapg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sapg_pkg::VOL_W-1:0]         csr_wdata
);
   import sapg_pkg::*;

   // pipeline advances unless a finished result is held up
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // volume registers
   logic [VOL_W-1:0] max_volume_ff;
   logic [VOL_W-1:0] min_volume_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_volume_ff <= VOL_RESET;
         min_volume_ff <= VOL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_VOLUME: max_volume_ff <= csr_wdata;
            CSR_MIN_VOLUME: min_volume_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits following the data
   logic [PIPE_LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
   end

   assign rsp_valid = vld_ff[PIPE_LAT-1];

   // front end
   sapg_prod_type prod;

   sapg_front u_front (
      .clock     (clock),
      .adv       (adv),
      .req_data  (req_data),
      .prod_data (prod)
   );

   // vector lengths
   logic [ROOT_W-1:0] len_l;
   logic [ROOT_W-1:0] len_d;
   logic [ROOT_W-1:0] len_s;

   sapg_isqrt u_isqrt_l (
      .clock (clock),
      .adv   (adv),
      .rad   ({prod.aa_l, NORM_SHIFT_BITS'(0)}),
      .root  (len_l)
   );

   sapg_isqrt u_isqrt_d (
      .clock (clock),
      .adv   (adv),
      .rad   ({prod.aa_d, NORM_SHIFT_BITS'(0)}),
      .root  (len_d)
   );

   sapg_isqrt u_isqrt_s (
      .clock (clock),
      .adv   (adv),
      .rad   ({prod.aa_s, NORM_SHIFT_BITS'(0)}),
      .root  (len_s)
   );

   // dot products wait for the lengths and the denominators
   logic [DOT_PAIR_W-1:0] dots_dly;

   sapg_delay #(
      .WIDTH (DOT_PAIR_W),
      .DEPTH (DOT_DLY)
   ) u_dot_dly (
      .clock (clock),
      .adv   (adv),
      .d_in  ({prod.dot1_mag, prod.dot1_neg, prod.dot2_mag, prod.dot2_neg}),
      .d_out (dots_dly)
   );

   logic zero_dly;

   sapg_delay #(
      .WIDTH (1),
      .DEPTH (ZERO_DLY)
   ) u_zero_dly (
      .clock (clock),
      .adv   (adv),
      .d_in  (prod.zero),
      .d_out (zero_dly)
   );

   // length products
   logic [DEN_W-1:0] den1_ff;
   logic [DEN_W-1:0] den2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         den1_ff <= len_l * len_d;
         den2_ff <= len_l * len_s;
      end
   end

   // cosines
   logic signed [COS_W-1:0] cos1;
   logic signed [COS_W-1:0] cos2;

   sapg_div u_div_pan (
      .clock   (clock),
      .adv     (adv),
      .dot_mag (dots_dly[DOT_PAIR_W-1 -: DOT_W]),
      .dot_neg (dots_dly[DOT_W+1]),
      .den     (den1_ff),
      .cos_q15 (cos1)
   );

   sapg_div u_div_vol (
      .clock   (clock),
      .adv     (adv),
      .dot_mag (dots_dly[DOT_W:1]),
      .dot_neg (dots_dly[0]),
      .den     (den2_ff),
      .cos_q15 (cos2)
   );

   // pan, volume blend and gain
   sapg_mix u_mix (
      .clock      (clock),
      .adv        (adv),
      .cos1       (cos1),
      .cos2       (cos2),
      .zero       (zero_dly),
      .max_volume (max_volume_ff),
      .min_volume (min_volume_ff),
      .rsp_data   (rsp_data)
   );

   // degenerate geometry forces all values to zero
   a_zero_forces_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.gain == '0 && rsp_data.pan == '0 && rsp_data.blended_volume == '0)
      else $error("zero_length result carries nonzero values");

   // pan never exceeds 1.0
   a_pan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pan <= 16'(COS_ONE))
      else $error("pan above one");

   // pan <= 1.0, so gain cannot exceed the blended volume
   a_gain_le_vol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.gain <= rsp_data.blended_volume)
      else $error("gain above blended volume");

   // nothing leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

>>> hdl/sapg_delay.sv
// Enable-gated delay line that keeps side data aligned with the pipeline.
module sapg_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = sapg_pkg::ZERO_DLY
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);
   import sapg_pkg::*;

   logic [WIDTH-1:0] dly_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign d_out = dly_ff[DEPTH-1];

endmodule

>>> hdl/sapg_front.sv
// Front end: position difference, vector normalization, squares and dot products.
module sapg_front (
   input  logic                   clock,
   input  logic                   adv,
   input  sapg_pkg::sapg_req_type req_data,
   output sapg_pkg::sapg_prod_type prod_data
);
   import sapg_pkg::*;

   // stage 1: difference vector and component magnitudes
   logic [MAG_W-1:0] d_mag_ff [3];
   logic             d_neg_ff [3];
   logic [DIR_W-1:0] l_mag_ff [3];
   logic             l_neg_ff [3];
   logic [DIR_W-1:0] s_mag_ff [3];
   logic             s_neg_ff [3];

   logic [MAG_W-1:0] d_mag_in [3];
   logic             d_neg_in [3];
   logic [DIR_W-1:0] l_mag_in [3];
   logic             l_neg_in [3];
   logic [DIR_W-1:0] s_mag_in [3];
   logic             s_neg_in [3];

   always_comb begin
      logic signed [POS_W-1:0] lis [3];
      logic signed [POS_W-1:0] src [3];
      logic signed [DIR_W-1:0] ld  [3];
      logic signed [DIR_W-1:0] sd  [3];
      logic [MAG_W-1:0]        dif;
      lis[0] = req_data.listener_x;
      lis[1] = req_data.listener_y;
      lis[2] = req_data.listener_z;
      src[0] = req_data.source_x;
      src[1] = req_data.source_y;
      src[2] = req_data.source_z;
      ld[0]  = req_data.listener_dir_x;
      ld[1]  = req_data.listener_dir_y;
      ld[2]  = req_data.listener_dir_z;
      sd[0]  = req_data.source_dir_x;
      sd[1]  = req_data.source_dir_y;
      sd[2]  = req_data.source_dir_z;
      for (int i = 0; i < 3; i++) begin
         // listener-to-source, one bit wider so it cannot wrap
         dif = {src[i][POS_W-1], src[i]} - {lis[i][POS_W-1], lis[i]};
         d_neg_in[i] = dif[MAG_W-1];
         d_mag_in[i] = dif[MAG_W-1] ? (~dif + 1'b1) : dif;
         l_neg_in[i] = ld[i][DIR_W-1];
         l_mag_in[i] = ld[i][DIR_W-1] ? (~ld[i] + 1'b1) : ld[i];
         s_neg_in[i] = sd[i][DIR_W-1];
         s_mag_in[i] = sd[i][DIR_W-1] ? (~sd[i] + 1'b1) : sd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_mag_ff <= d_mag_in;
         d_neg_ff <= d_neg_in;
         l_mag_ff <= l_mag_in;
         l_neg_ff <= l_neg_in;
         s_mag_ff <= s_mag_in;
         s_neg_ff <= s_neg_in;
      end
   end

   // stage 2: scale each vector so its largest magnitude sits in [2^14, 2^15)
   logic [NORM_W-1:0] dn_ff [3];
   logic [NORM_W-1:0] ln_ff [3];
   logic [NORM_W-1:0] sn_ff [3];
   logic              dn_neg_ff [3];
   logic              ln_neg_ff [3];
   logic              sn_neg_ff [3];
   logic              zero_ff;

   logic [NORM_W-1:0] dn_in [3];
   logic [NORM_W-1:0] ln_in [3];
   logic [NORM_W-1:0] sn_in [3];
   logic              zero_in;

   always_comb begin
      logic [MAG_W-1:0] d_or;
      logic [MAG_W-1:0] l_or;
      logic [MAG_W-1:0] s_or;
      logic [MSB_W-1:0] d_p;
      logic [MSB_W-1:0] l_p;
      logic [MSB_W-1:0] s_p;
      // highest bit of the OR is the highest bit of the largest component
      d_or = d_mag_ff[0] | d_mag_ff[1] | d_mag_ff[2];
      l_or = MAG_W'(l_mag_ff[0] | l_mag_ff[1] | l_mag_ff[2]);
      s_or = MAG_W'(s_mag_ff[0] | s_mag_ff[1] | s_mag_ff[2]);
      d_p = msb_index(d_or);
      l_p = msb_index(l_or);
      s_p = msb_index(s_or);
      for (int i = 0; i < 3; i++) begin
         dn_in[i] = norm_mag(d_mag_ff[i], d_p);
         ln_in[i] = norm_mag(MAG_W'(l_mag_ff[i]), l_p);
         sn_in[i] = norm_mag(MAG_W'(s_mag_ff[i]), s_p);
      end
      zero_in = (d_or == '0) || (l_or == '0) || (s_or == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dn_ff     <= dn_in;
         ln_ff     <= ln_in;
         sn_ff     <= sn_in;
         dn_neg_ff <= d_neg_ff;
         ln_neg_ff <= l_neg_ff;
         sn_neg_ff <= s_neg_ff;
         zero_ff   <= zero_in;
      end
   end

   // stage 3: squared lengths and the two dot products
   sapg_prod_type prod_ff;
   sapg_prod_type prod_in;

   always_comb begin
      logic [2*NORM_W-1:0]   p1;
      logic [2*NORM_W-1:0]   p2;
      logic signed [DOT_W:0] dot1;
      logic signed [DOT_W:0] dot2;
      logic [SQ_W-1:0]       aa_l;
      logic [SQ_W-1:0]       aa_d;
      logic [SQ_W-1:0]       aa_s;
      dot1 = '0;
      dot2 = '0;
      aa_l = '0;
      aa_d = '0;
      aa_s = '0;
      for (int i = 0; i < 3; i++) begin
         aa_l = aa_l + SQ_W'(ln_ff[i] * ln_ff[i]);
         aa_d = aa_d + SQ_W'(dn_ff[i] * dn_ff[i]);
         aa_s = aa_s + SQ_W'(sn_ff[i] * sn_ff[i]);
         p1 = ln_ff[i] * dn_ff[i];
         p2 = ln_ff[i] * sn_ff[i];
         if (ln_neg_ff[i] != dn_neg_ff[i]) dot1 = dot1 - $signed((DOT_W+1)'(p1));
         else dot1 = dot1 + $signed((DOT_W+1)'(p1));
         if (ln_neg_ff[i] != sn_neg_ff[i]) dot2 = dot2 - $signed((DOT_W+1)'(p2));
         else dot2 = dot2 + $signed((DOT_W+1)'(p2));
      end
      prod_in.aa_l     = aa_l;
      prod_in.aa_d     = aa_d;
      prod_in.aa_s     = aa_s;
      prod_in.dot1_neg = dot1[DOT_W];
      prod_in.dot1_mag = dot1[DOT_W] ? DOT_W'(-dot1) : DOT_W'(dot1);
      prod_in.dot2_neg = dot2[DOT_W];
      prod_in.dot2_mag = dot2[DOT_W] ? DOT_W'(-dot2) : DOT_W'(dot2);
      prod_in.zero     = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) prod_ff <= prod_in;
   end

   assign prod_data = prod_ff;

endmodule

>>> hdl/sapg_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module sapg_isqrt (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [sapg_pkg::RAD_W-1:0]  rad,
   output logic [sapg_pkg::ROOT_W-1:0] root
);
   import sapg_pkg::*;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W-1];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      logic [REM_W-1:0]  prev_rem;
      logic [ROOT_W-1:0] prev_root;
      logic [RAD_W-1:0]  prev_rad;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (g == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_rad  = rad;
      end else begin : g_next
         assign prev_rem  = rem_ff[g-1];
         assign prev_root = root_ff[g-1];
         assign prev_rad  = rad_ff[g-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         cur   = {prev_rem, prev_rad[RAD_W-1 -: 2]};
         trial = {3'b000, prev_root, 2'b01};
         if (cur >= trial) begin
            rem_in  = REM_W'(cur - trial);
            root_in = {prev_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(cur);
            root_in = {prev_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
         end
      end

      if (g < ROOT_W - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (adv) rad_ff[g] <= prev_rad << 2;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

>>> hdl/sapg_div.sv
// Pipelined rounded divider producing a clamped signed Q1.15 cosine.
module sapg_div (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [sapg_pkg::DOT_W-1:0]        dot_mag,
   input  logic                              dot_neg,
   input  logic [sapg_pkg::DEN_W-1:0]        den,
   output logic signed [sapg_pkg::COS_W-1:0] cos_q15
);
   import sapg_pkg::*;

   localparam int CMP_W = NUM_W + 1;

   logic [NUM_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             sat_ff [QUO_W+1];

   // setup: dividend = |dot| * 2^29 + den/2, overflow check against den * 2^17
   logic [NUM_W-1:0] num_in;
   logic             sat_in;

   always_comb begin
      num_in = {dot_mag, 29'd0} + NUM_W'(den >> 1);
      sat_in = CMP_W'(num_in) >= (CMP_W'(den) << QUO_W);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num_in;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         neg_ff[0] <= dot_neg;
         sat_ff[0] <= sat_in;
      end
   end

   // restoring steps, quotient bit QUO_W-1-g in step g
   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic [CMP_W-1:0] dsh;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         dsh    = CMP_W'(den_ff[g]) << (QUO_W - 1 - g);
         rem_in = rem_ff[g];
         quo_in = quo_ff[g];
         if (CMP_W'(rem_ff[g]) >= dsh) begin
            rem_in = NUM_W'(CMP_W'(rem_ff[g]) - dsh);
            quo_in[QUO_W-1-g] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g+1] <= rem_in;
            den_ff[g+1] <= den_ff[g];
            quo_ff[g+1] <= quo_in;
            neg_ff[g+1] <= neg_ff[g];
            sat_ff[g+1] <= sat_ff[g];
         end
      end
   end

   // clamp to one and apply the sign
   logic signed [COS_W-1:0] cos_ff;
   logic signed [COS_W-1:0] cos_in;

   always_comb begin
      logic [QUO_W-1:0] q;
      q = quo_ff[QUO_W];
      if (sat_ff[QUO_W] || (q > COS_ONE)) q = COS_ONE;
      cos_in = neg_ff[QUO_W] ? -$signed(q) : $signed(q);
   end

   always_ff @(posedge clock) begin
      if (adv) cos_ff <= cos_in;
   end

   assign cos_q15 = cos_ff;

endmodule

>>> hdl/sapg_mix.sv
// Back end: pan from the first cosine, volume blend from the second, gain product.
module sapg_mix (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [sapg_pkg::COS_W-1:0] cos1,
   input  logic signed [sapg_pkg::COS_W-1:0] cos2,
   input  logic                              zero,
   input  logic [sapg_pkg::VOL_W-1:0]        max_volume,
   input  logic [sapg_pkg::VOL_W-1:0]        min_volume,
   output sapg_pkg::sapg_rsp_type            rsp_data
);
   import sapg_pkg::*;

   // m1: pan = (c1 + 1 + half) / 2, weight = c2 + 1
   logic [VOL_W-1:0] pan1_ff;
   logic [16:0]      w1_ff;
   logic             z1_ff;
   logic [17:0]      pan_sum;
   logic [17:0]      w_sum;

   always_comb begin
      pan_sum = {cos1[COS_W-1], cos1} + PAN_OFFSET;
      w_sum   = {cos2[COS_W-1], cos2} + W_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pan1_ff <= pan_sum[16:1];
         w1_ff   <= w_sum[16:0];
         z1_ff   <= zero;
      end
   end

   // m2: weighted sum of the two volume registers
   logic [33:0]      sum2_ff;
   logic [VOL_W-1:0] pan2_ff;
   logic             z2_ff;
   logic [33:0]      sum2_in;

   always_comb begin
      logic [16:0] omw;
      omw     = 17'(W_FULL - {1'b0, w1_ff});
      sum2_in = (34'(min_volume) * 34'(omw)) + (34'(max_volume) * 34'(w1_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum2_ff <= sum2_in;
         pan2_ff <= pan1_ff;
         z2_ff   <= z1_ff;
      end
   end

   // m3: round the blend back to Q1.15
   logic [VOL_W-1:0] vol3_ff;
   logic [VOL_W-1:0] pan3_ff;
   logic             z3_ff;
   logic [33:0]      vol_sum;

   assign vol_sum = sum2_ff + VOL_HALF;

   always_ff @(posedge clock) begin
      if (adv) begin
         vol3_ff <= vol_sum[31:16];
         pan3_ff <= pan2_ff;
         z3_ff   <= z2_ff;
      end
   end

   // m4: pan times volume
   logic [31:0]      prod4_ff;
   logic [VOL_W-1:0] vol4_ff;
   logic [VOL_W-1:0] pan4_ff;
   logic             z4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod4_ff <= pan3_ff * vol3_ff;
         vol4_ff  <= vol3_ff;
         pan4_ff  <= pan3_ff;
         z4_ff    <= z3_ff;
      end
   end

   // m5: round, saturate, force zero on a degenerate vector; output register
   sapg_rsp_type rsp_ff;
   sapg_rsp_type rsp_in;

   always_comb begin
      logic [32:0] g_sum;
      logic [17:0] g;
      g_sum = {1'b0, prod4_ff} + GAIN_HALF;
      g     = g_sum[32:15];
      rsp_in.gain           = (g > 18'(GAIN_MAX)) ? GAIN_MAX : g[VOL_W-1:0];
      rsp_in.pan            = pan4_ff;
      rsp_in.blended_volume = vol4_ff;
      rsp_in.zero_length    = z4_ff;
      if (z4_ff) begin
         rsp_in.gain           = '0;
         rsp_in.pan            = '0;
         rsp_in.blended_volume = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sim/spatial_audio_pan_gain_unit_tb.sv
// Self-checking testbench of the spatial audio pan/gain unit.
module spatial_audio_pan_gain_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sapg_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE = PIPE_LAT + 10;

   // Expected-gain model and result store
   class gain_scoreboard;
      sapg_rsp_type expected_q[$];
      int unsigned max_vol = 32768;
      int unsigned min_vol = 32768;
      int errors = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [VOL_W-1:0] val);
         if (idx == CSR_MAX_VOLUME) max_vol = val;
         else if (idx == CSR_MIN_VOLUME) min_vol = val;
      endfunction

      // Scale so the largest magnitude is in [16384, 32767]
      function bit scale(ref longint unsigned m[3]);
         longint unsigned mx;
         mx = 0;
         foreach (m[i]) if (m[i] > mx) mx = m[i];
         if (mx == 0) return 0;
         while (mx >= 32768) begin
            foreach (m[i]) m[i] >>= 1;
            mx >>= 1;
         end
         while (mx < 16384) begin
            foreach (m[i]) m[i] <<= 1;
            mx <<= 1;
         end
         return 1;
      endfunction

      function longint unsigned floor_sqrt(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Signed Q1.15 cosine of two scaled vectors
      function int cosine(longint unsigned am[3], bit an[3],
                          longint unsigned bm[3], bit bn[3]);
         longint unsigned aa, bb, den, q, mag;
         longint dot;
         aa = 0; bb = 0; dot = 0;
         for (int i = 0; i < 3; i++) begin
            aa += am[i] * am[i];
            bb += bm[i] * bm[i];
            if (an[i] != bn[i]) dot -= longint'(am[i] * bm[i]);
            else dot += longint'(am[i] * bm[i]);
         end
         den = floor_sqrt(aa << 14) * floor_sqrt(bb << 14);
         if (den == 0) return 0;
         mag = dot < 0 ? longint'(-dot) : longint'(dot);
         q = ((mag << 29) + den / 2) / den;
         if (q > 32768) q = 32768;
         return dot < 0 ? -int'(q) : int'(q);
      endfunction

      function void note_request(sapg_req_type r);
         longint unsigned dm[3], lm[3], sm[3];
         bit dn[3], ln[3], sn[3];
         longint dv[3], lv[3], sv[3];
         bit ok;
         int c1, c2;
         longint unsigned pan, w, vol, g;
         sapg_rsp_type e;
         dv[0] = longint'(r.source_x) - longint'(r.listener_x);
         dv[1] = longint'(r.source_y) - longint'(r.listener_y);
         dv[2] = longint'(r.source_z) - longint'(r.listener_z);
         lv[0] = r.listener_dir_x; lv[1] = r.listener_dir_y; lv[2] = r.listener_dir_z;
         sv[0] = r.source_dir_x; sv[1] = r.source_dir_y; sv[2] = r.source_dir_z;
         for (int i = 0; i < 3; i++) begin
            dn[i] = dv[i] < 0; dm[i] = dn[i] ? -dv[i] : dv[i];
            ln[i] = lv[i] < 0; lm[i] = ln[i] ? -lv[i] : lv[i];
            sn[i] = sv[i] < 0; sm[i] = sn[i] ? -sv[i] : sv[i];
         end
         ok = scale(dm);
         ok = scale(lm) && ok;
         ok = scale(sm) && ok;
         e = '0;
         if (!ok) begin
            e.zero_length = 1'b1;
         end else begin
            c1 = cosine(lm, ln, dm, dn);
            c2 = cosine(lm, ln, sm, sn);
            pan = longint'(c1 + 32769) >> 1;
            w = longint'(c2 + 32768);
            vol = (longint'(min_vol) * (65536 - w) + longint'(max_vol) * w + 32768) >> 16;
            g = (pan * vol + 16384) >> 15;
            if (g > 65535) g = 65535;
            e.gain = g[15:0];
            e.pan = pan[15:0];
            e.blended_volume = vol[15:0];
         end
         expected_q.push_back(e);
      endfunction

      function void check_result(sapg_rsp_type got);
         sapg_rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         e = expected_q.pop_front();
         if (got.gain !== e.gain || got.pan !== e.pan ||
             got.blended_volume !== e.blended_volume || got.zero_length !== e.zero_length) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: gain %0d/%0d pan %0d/%0d vol %0d/%0d zero %0b/%0b (exp/act)",
                        e.gain, got.gain, e.pan, got.pan, e.blended_volume,
                        got.blended_volume, e.zero_length, got.zero_length);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_we;
   sapg_req_type req_data;
   sapg_rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VOL_W-1:0] csr_wdata;

   gain_scoreboard sb = new();
   int idle_cycles = 0;
   int stall_mode = 0;

   spatial_audio_pan_gain_unit dut (.*);

   always #4 clock = ~clock;

   // Result side: check, stall pattern, watchdog
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if ($urandom_range(99) == 0) stall_mode = $urandom_range(2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(3) == 0);
         default: rsp_stall <= ($urandom_range(7) < 5);
      endcase
   end

   // Hold one transaction until accepted
   task automatic send(sapg_req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic pause(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [VOL_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [DIR_W-1:0] rand_dir();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return DIR_W'($urandom_range(32) - 16);
         default: return DIR_W'($urandom);
      endcase
   endfunction

   // Random transaction with mixed position spreads and corner facings
   function automatic sapg_req_type rand_item();
      sapg_req_type r;
      int kind;
      kind = $urandom_range(19);
      r.listener_x = $urandom; r.listener_y = $urandom; r.listener_z = $urandom;
      case (kind % 4)
         0: begin
            r.source_x = $urandom; r.source_y = $urandom; r.source_z = $urandom;
         end
         1: begin
            r.source_x = r.listener_x + ($urandom_range(8) - 4);
            r.source_y = r.listener_y + ($urandom_range(8) - 4);
            r.source_z = r.listener_z + ($urandom_range(8) - 4);
         end
         2: begin
            r.source_x = r.listener_x + ($urandom_range(2000000) - 1000000);
            r.source_y = r.listener_y + ($urandom_range(2000000) - 1000000);
            r.source_z = r.listener_z + ($urandom_range(2000000) - 1000000);
         end
         default: begin
            r.source_x = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            r.source_y = $urandom; r.source_z = $urandom;
         end
      endcase
      if (kind == 19) begin
         r.source_x = r.listener_x; r.source_y = r.listener_y; r.source_z = r.listener_z;
      end
      r.listener_dir_x = rand_dir(); r.listener_dir_y = rand_dir(); r.listener_dir_z = rand_dir();
      r.source_dir_x = rand_dir(); r.source_dir_y = rand_dir(); r.source_dir_z = rand_dir();
      // facings equal or opposite
      if (kind == 5) begin
         r.source_dir_x = r.listener_dir_x; r.source_dir_y = r.listener_dir_y;
         r.source_dir_z = r.listener_dir_z;
      end else if (kind == 6) begin
         r.source_dir_x = -r.listener_dir_x; r.source_dir_y = -r.listener_dir_y;
         r.source_dir_z = -r.listener_dir_z;
      end
      return r;
   endfunction

   function automatic sapg_req_type axis_item(int dx, int ldx, int sdx);
      sapg_req_type r;
      r = '0;
      r.source_x = dx;
      r.listener_dir_x = DIR_W'(ldx); r.source_dir_x = DIR_W'(sdx);
      return r;
   endfunction

   initial begin
      sapg_req_type r;
      logic [VOL_W-1:0] vols[7][2] = '{'{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF},
         '{16'hFFFF, 16'd0}, '{16'd0, 16'hFFFF}, '{16'd32768, 16'd32768},
         '{16'd40000, 16'd12345}, '{16'd0, 16'd0}};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset volumes, on-axis, opposite, zero vectors, extremes
      send(axis_item(65536, 16384, 16384));
      send(axis_item(-65536, 16384, 16384));
      send(axis_item(65536, 16384, -16384));
      send(axis_item(1, -32768, 32767));
      send(axis_item(0, 16384, 16384));
      send(axis_item(65536, 0, 16384));
      send(axis_item(65536, 16384, 0));
      r = '0;
      r.listener_x = 32'sh80000000; r.listener_y = 32'sh7FFFFFFF; r.listener_z = 32'sh80000000;
      r.source_x = 32'sh7FFFFFFF; r.source_y = 32'sh80000000; r.source_z = 32'sh7FFFFFFF;
      r.listener_dir_x = 16'sh8000; r.listener_dir_y = 16'sh8000; r.listener_dir_z = 16'sh8000;
      r.source_dir_x = 16'sh7FFF; r.source_dir_y = 16'sh7FFF; r.source_dir_z = 16'sh7FFF;
      send(r);
      r.source_dir_x = 16'sh8000; r.source_dir_y = 16'sh8000; r.source_dir_z = 16'sh8000;
      send(r);
      r.listener_dir_x = 16'sd1; r.listener_dir_y = 16'sd0; r.listener_dir_z = 16'sd0;
      r.source_dir_x = 16'sd3; r.source_dir_y = 16'sd0; r.source_dir_z = -16'sd1;
      send(r);
      repeat (8) send(rand_item());
      drain();
      // Ignored register indexes leave the volumes untouched
      write_csr(2'd2, 16'd1);
      write_csr(2'd3, 16'd2);
      send(axis_item(65536, 16384, 16384));
      send(axis_item(65536, 16384, -16384));

      // Random phases, one volume setting each
      for (int p = 0; p < 7; p++) begin
         drain();
         if (p == 6) begin
            vols[6][0] = VOL_W'($urandom); vols[6][1] = VOL_W'($urandom);
         end
         write_csr(CSR_MAX_VOLUME, vols[p][0]);
         write_csr(CSR_MIN_VOLUME, vols[p][1]);
         for (int n = 0; n < 270; ) begin
            int burst;
            burst = $urandom_range(40, 1);
            for (int k = 0; k < burst && n < 270; k++, n++) send(rand_item());
            if ($urandom_range(3) == 0) begin
               pause($urandom_range(20, 1));
            end else if ($urandom_range(15) == 0) begin
               req_valid <= 1'b0;
               while (sb.expected_q.size() != 0) @(posedge clock);
            end
         end
      end
      drain();
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
